// File: hdl/gsm2u_pkg.sv
// gsm2u_pkg: types, tables and encoder for the GSM 03.38 to UTF-8 converter.
// Used by the interfaces and every module of the block; depends on nothing.

package gsm2u_pkg;

  localparam int GsmW      = 8;
  localparam int ByteW     = 8;
  localparam int CpW       = 14;  // widest code point is the euro sign
  localparam int BaseW     = 10;  // widest default-alphabet code point
  localparam int MaxBytes  = 3;
  localparam int CntW      = 2;
  localparam int FifoDepth = 2;
  localparam int PtrW      = $clog2(FifoDepth);

  localparam logic [GsmW-1:0]  EscCode = 8'd27;
  localparam logic [ByteW-1:0] NotRepr = 8'h3F;  // '?'

  // One request's worth of output bytes, bytes[0] goes out first
  typedef struct packed {
    logic [CntW-1:0]                   cnt;
    logic [MaxBytes-1:0][ByteW-1:0]    bytes;
  } job_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic valid;
    job_t job;
  } head_t;

  // Default alphabet, index is the septet value
  localparam logic [BaseW-1:0] BaseMap [128] = '{
    10'h040, 10'h0A3, 10'h024, 10'h0A5, 10'h0E8, 10'h0E9, 10'h0F9, 10'h0EC,
    10'h0F2, 10'h0C7, 10'h00A, 10'h0D8, 10'h0F8, 10'h00D, 10'h0C5, 10'h0E5,
    10'h394, 10'h05F, 10'h3A6, 10'h393, 10'h39B, 10'h3A9, 10'h3A0, 10'h3A8,
    10'h3A3, 10'h398, 10'h39E, 10'h03F, 10'h0C6, 10'h0E6, 10'h0DF, 10'h0C9,
    10'h020, 10'h021, 10'h022, 10'h023, 10'h0A4, 10'h025, 10'h026, 10'h027,
    10'h028, 10'h029, 10'h02A, 10'h02B, 10'h02C, 10'h02D, 10'h02E, 10'h02F,
    10'h030, 10'h031, 10'h032, 10'h033, 10'h034, 10'h035, 10'h036, 10'h037,
    10'h038, 10'h039, 10'h03A, 10'h03B, 10'h03C, 10'h03D, 10'h03E, 10'h03F,
    10'h0A1, 10'h041, 10'h042, 10'h043, 10'h044, 10'h045, 10'h046, 10'h047,
    10'h048, 10'h049, 10'h04A, 10'h04B, 10'h04C, 10'h04D, 10'h04E, 10'h04F,
    10'h050, 10'h051, 10'h052, 10'h053, 10'h054, 10'h055, 10'h056, 10'h057,
    10'h058, 10'h059, 10'h05A, 10'h0C4, 10'h0D6, 10'h0D1, 10'h0DC, 10'h0A7,
    10'h0BF, 10'h061, 10'h062, 10'h063, 10'h064, 10'h065, 10'h066, 10'h067,
    10'h068, 10'h069, 10'h06A, 10'h06B, 10'h06C, 10'h06D, 10'h06E, 10'h06F,
    10'h070, 10'h071, 10'h072, 10'h073, 10'h074, 10'h075, 10'h076, 10'h077,
    10'h078, 10'h079, 10'h07A, 10'h0E4, 10'h0F6, 10'h0F1, 10'h0FC, 10'h0E0
  };

  // Extension table lookup; bit CpW is the hit flag
  function automatic logic [CpW:0] ext_lookup(input logic [GsmW-1:0] b);
    logic [CpW:0] r;
    r = '0;
    case (b)
      8'd10:   r = {1'b1, 14'h000C};
      8'd20:   r = {1'b1, 14'h005E};
      8'd40:   r = {1'b1, 14'h007B};
      8'd41:   r = {1'b1, 14'h007D};
      8'd47:   r = {1'b1, 14'h005C};
      8'd60:   r = {1'b1, 14'h005B};
      8'd61:   r = {1'b1, 14'h007E};
      8'd62:   r = {1'b1, 14'h005D};
      8'd64:   r = {1'b1, 14'h007C};
      8'd101:  r = {1'b1, 14'h20AC};
      default: r = '0;
    endcase
    return r;
  endfunction

  // UTF-8 encoding of a code point below 0x4000
  function automatic job_t utf8_encode(input logic [CpW-1:0] cp);
    job_t j;
    j = '0;
    if (cp < 14'h0080) begin
      j.cnt      = 2'd1;
      j.bytes[0] = {1'b0, cp[6:0]};
    end else if (cp < 14'h0800) begin
      j.cnt      = 2'd2;
      j.bytes[0] = {3'b110, cp[10:6]};
      j.bytes[1] = {2'b10, cp[5:0]};
    end else begin
      j.cnt      = 2'd3;
      j.bytes[0] = {6'b111000, cp[13:12]};
      j.bytes[1] = {2'b10, cp[11:6]};
      j.bytes[2] = {2'b10, cp[5:0]};
    end
    return j;
  endfunction

endpackage

// File: hdl/gsm2u_if.sv
// gsm2u_in_if / gsm2u_out_if: valid-ready channels of the converter.
// Depends on gsm2u_pkg for field widths.

interface gsm2u_in_if;
  logic                           valid;
  logic                           ready;
  logic [gsm2u_pkg::GsmW-1:0]     gsm_byte;
  logic                           last_in_message;

  modport source (output valid, output gsm_byte, output last_in_message, input ready);
  modport sink   (input valid, input gsm_byte, input last_in_message, output ready);
endinterface

interface gsm2u_out_if;
  logic                           valid;
  logic                           ready;
  logic [gsm2u_pkg::ByteW-1:0]    utf8_byte;
  logic                           last_of_run;

  modport source (output valid, output utf8_byte, output last_of_run, input ready);
  modport sink   (input valid, input utf8_byte, input last_of_run, output ready);
endinterface

// File: hdl/gsm2u_front.sv
// gsm2u_front: accepts septets, tracks a pending escape and builds the
// list of UTF-8 bytes for each request. Depends on gsm2u_pkg.

module gsm2u_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [7:0]        gsm_byte_i,
  input  logic              last_i,
  input  logic              accept_i,
  output gsm2u_pkg::job_t   job_o,
  output logic              push_o
);
  import gsm2u_pkg::*;

  logic         pend_q, pend_d;
  logic [CpW:0] ext_res;
  logic         ext_hit;
  logic         is_esc_open;
  logic         base_en;
  job_t         enc_ext, enc_base, job;
  logic [CntW-1:0] base_cnt;

  // Table lookups and encodings for both paths
  assign ext_res     = ext_lookup(gsm_byte_i);
  assign ext_hit     = ext_res[CpW];
  assign enc_ext     = utf8_encode(ext_res[CpW-1:0]);
  assign enc_base    = utf8_encode({{(CpW-BaseW){1'b0}}, BaseMap[gsm_byte_i[6:0]]});
  assign is_esc_open = (gsm_byte_i == EscCode) && !last_i;
  assign base_en     = !gsm_byte_i[7] && !is_esc_open;
  assign base_cnt    = base_en ? enc_base.cnt : '0;

  // Assemble the byte list, with a leading '?' for an unresolved escape
  always_comb begin
    job    = '0;
    pend_d = pend_q;
    if (pend_q && ext_hit) begin
      job    = enc_ext;
      pend_d = 1'b0;
    end else if (pend_q) begin
      job.bytes[0] = NotRepr;
      job.bytes[1] = enc_base.bytes[0];
      job.bytes[2] = enc_base.bytes[1];
      job.cnt      = base_cnt + 2'd1;
      pend_d       = is_esc_open;
    end else begin
      job.bytes = enc_base.bytes;
      job.cnt   = base_cnt;
      pend_d    = is_esc_open;
    end
  end

  assign job_o  = job;
  assign push_o = accept_i && (job.cnt != '0);

  // Escape state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else if (accept_i) begin
      pend_q <= pend_d;
    end
  end

endmodule

// File: hdl/gsm2u_fifo.sv
// gsm2u_fifo: short request queue between front and back end.
// Depends on gsm2u_pkg.

module gsm2u_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  gsm2u_pkg::job_t   job_i,
  output logic              full_o,
  input  logic              pop_i,
  output gsm2u_pkg::head_t  head_o
);
  import gsm2u_pkg::*;

  job_t              mem_q [FifoDepth];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [PtrW:0]     cnt_q;

  assign full_o       = (cnt_q == (PtrW+1)'(FifoDepth));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.job   = mem_q[rd_q];

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(FifoDepth-1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(FifoDepth-1)) ? '0 : rd_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// File: hdl/gsm2u_back.sv
// gsm2u_back: walks the queued byte lists and drives the output register.
// Depends on gsm2u_pkg.

module gsm2u_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gsm2u_pkg::head_t   head_i,
  output logic               pop_o,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [7:0]         utf8_byte_o,
  output logic               last_o
);
  import gsm2u_pkg::*;

  logic [CntW-1:0]  idx_q, idx_d;
  logic             ov_q, ov_d;
  logic [ByteW-1:0] byte_q;
  logic             last_q;
  logic             load;
  logic             final_byte;

  assign load       = head_i.valid && (!ov_q || out_ready_i);
  assign final_byte = ((idx_q + 2'd1) == head_i.job.cnt);
  assign pop_o      = load && final_byte;

  // Byte index within the current request
  always_comb begin
    idx_d = idx_q;
    if (load) begin
      idx_d = final_byte ? '0 : idx_q + 2'd1;
    end
    ov_d = load ? 1'b1 : (out_ready_i ? 1'b0 : ov_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      idx_q <= idx_d;
      ov_q  <= ov_d;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= head_i.job.bytes[idx_q];
      last_q <= final_byte;
    end
  end

  assign out_valid_o = ov_q;
  assign utf8_byte_o = byte_q;
  assign last_o      = last_q;

endmodule

// File: hdl/gsm_alphabet_to_utf8.sv
// gsm_alphabet_to_utf8: GSM 03.38 septets in, UTF-8 bytes out.
// Accepted requests enter the queue; the output register loads from its head.
// Throughput: one output byte per cycle unless the output is stalled; a request
// gives up to 3 bytes; the single-byte output register sets that rate.
// A two-entry queue lets input be taken while output is stalled.
// Reset (rst_ni low, asynchronous) clears the escape flag, queue and output.

module gsm_alphabet_to_utf8 (
  input  logic         clk_i,
  input  logic         rst_ni,
  gsm2u_in_if.sink     in_if,
  gsm2u_out_if.source  out_if
);
  import gsm2u_pkg::*;

  job_t  job;
  head_t head;
  logic  push, pop, full, accept;

  assign in_if.ready = !full;
  assign accept      = in_if.valid && !full;

  gsm2u_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .gsm_byte_i (in_if.gsm_byte),
    .last_i     (in_if.last_in_message),
    .accept_i   (accept),
    .job_o      (job),
    .push_o     (push)
  );

  gsm2u_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job),
    .full_o (full),
    .pop_i  (pop),
    .head_o (head)
  );

  gsm2u_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .out_ready_i (out_if.ready),
    .out_valid_o (out_if.valid),
    .utf8_byte_o (out_if.utf8_byte),
    .last_o      (out_if.last_of_run)
  );

endmodule

// File: hdl/gsm2u_checker.sv
// gsm2u_checker: port-level checks on the converter output stream,
// bound to gsm_alphabet_to_utf8. Depends on gsm2u_pkg.

module gsm2u_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] utf8_byte_i,
  input logic       last_of_run_i
);
  import gsm2u_pkg::*;

  // Output is idle while in reset
  assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("output valid during reset");

  // A stalled output byte holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(utf8_byte_i)
      && $stable(last_of_run_i))
    else $error("stalled output changed");

  // A multi-byte lead byte never ends a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (utf8_byte_i[7:6] == 2'b11) |-> !last_of_run_i)
    else $error("lead byte flagged as last");

  // The only ASCII byte that may be followed by more is the escape '?'
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !utf8_byte_i[7] && !last_of_run_i |-> utf8_byte_i == NotRepr)
    else $error("unexpected non-final ASCII byte");

endmodule

bind gsm_alphabet_to_utf8 gsm2u_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_if.valid),
  .out_ready_i   (out_if.ready),
  .utf8_byte_i   (out_if.utf8_byte),
  .last_of_run_i (out_if.last_of_run)
);

// File: bench/testbench.sv
// testbench: self-checking bench for gsm_alphabet_to_utf8 (GSM septets in, UTF-8 bytes out).
// Drives a directed table then random messages, predicts every byte, checks in order.
// Depends on hdl/gsm2u_pkg.sv, hdl/gsm2u_if.sv and hdl/gsm_alphabet_to_utf8.sv.
`timescale 1ns / 100ps

module testbench;
  import gsm2u_pkg::*;

  // One expected or observed output byte
  typedef struct packed {
    logic [7:0] utf8_byte;
    logic       last_of_run;
  } utf8_beat_t;

  // Directed row: request plus, where typed in, the bytes it must produce
  typedef struct packed {
    logic [7:0] septet;
    logic       last;
    logic       typed;
    logic [1:0] cnt;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
  } dir_row_t;

  localparam int NumDirRows = 23;
  localparam int RandItems  = 450;
  localparam int DrainWait  = 10;

  // Default alphabet as code points, index is the septet
  localparam logic [15:0] SeptetCp [128] = '{
    16'h040, 16'h0A3, 16'h024, 16'h0A5, 16'h0E8, 16'h0E9, 16'h0F9, 16'h0EC,
    16'h0F2, 16'h0C7, 16'h00A, 16'h0D8, 16'h0F8, 16'h00D, 16'h0C5, 16'h0E5,
    16'h394, 16'h05F, 16'h3A6, 16'h393, 16'h39B, 16'h3A9, 16'h3A0, 16'h3A8,
    16'h3A3, 16'h398, 16'h39E, 16'h03F, 16'h0C6, 16'h0E6, 16'h0DF, 16'h0C9,
    16'h020, 16'h021, 16'h022, 16'h023, 16'h0A4, 16'h025, 16'h026, 16'h027,
    16'h028, 16'h029, 16'h02A, 16'h02B, 16'h02C, 16'h02D, 16'h02E, 16'h02F,
    16'h030, 16'h031, 16'h032, 16'h033, 16'h034, 16'h035, 16'h036, 16'h037,
    16'h038, 16'h039, 16'h03A, 16'h03B, 16'h03C, 16'h03D, 16'h03E, 16'h03F,
    16'h0A1, 16'h041, 16'h042, 16'h043, 16'h044, 16'h045, 16'h046, 16'h047,
    16'h048, 16'h049, 16'h04A, 16'h04B, 16'h04C, 16'h04D, 16'h04E, 16'h04F,
    16'h050, 16'h051, 16'h052, 16'h053, 16'h054, 16'h055, 16'h056, 16'h057,
    16'h058, 16'h059, 16'h05A, 16'h0C4, 16'h0D6, 16'h0D1, 16'h0DC, 16'h0A7,
    16'h0BF, 16'h061, 16'h062, 16'h063, 16'h064, 16'h065, 16'h066, 16'h067,
    16'h068, 16'h069, 16'h06A, 16'h06B, 16'h06C, 16'h06D, 16'h06E, 16'h06F,
    16'h070, 16'h071, 16'h072, 16'h073, 16'h074, 16'h075, 16'h076, 16'h077,
    16'h078, 16'h079, 16'h07A, 16'h0E4, 16'h0F6, 16'h0F1, 16'h0FC, 16'h0E0
  };

  // Extension table: septet after an escape and its code point
  localparam logic [7:0]  ExtKey [10] = '{8'd10, 8'd20, 8'd40, 8'd41, 8'd47,
                                          8'd60, 8'd61, 8'd62, 8'd64, 8'd101};
  localparam logic [15:0] ExtCp  [10] = '{16'h000C, 16'h005E, 16'h007B, 16'h007D,
                                          16'h005C, 16'h005B, 16'h007E, 16'h005D,
                                          16'h007C, 16'h20AC};

  // Directed table: extremes, drops, escapes in every position
  localparam dir_row_t DirRows [NumDirRows] = '{
    '{8'h00,   1'b0, 1'b1, 2'd1, 8'h40,   8'h00,   8'h00},  // '@'
    '{8'h7F,   1'b0, 1'b1, 2'd2, 8'hC3,   8'hA0,   8'h00},  // a-grave
    '{8'h80,   1'b0, 1'b1, 2'd0, 8'h00,   8'h00,   8'h00},  // dropped
    '{8'hFF,   1'b1, 1'b1, 2'd0, 8'h00,   8'h00,   8'h00},  // dropped
    '{8'h10,   1'b0, 1'b1, 2'd2, 8'hCE,   8'h94,   8'h00},  // Greek Delta
    '{EscCode, 1'b0, 1'b1, 2'd0, 8'h00,   8'h00,   8'h00},
    '{8'd101,  1'b0, 1'b1, 2'd3, 8'hE2,   8'h82,   8'hAC},  // euro
    '{EscCode, 1'b1, 1'b1, 2'd1, NotRepr, 8'h00,   8'h00},  // escape closes message
    '{EscCode, 1'b0, 1'b1, 2'd0, 8'h00,   8'h00,   8'h00},
    '{8'd10,   1'b0, 1'b1, 2'd1, 8'h0C,   8'h00,   8'h00},  // form feed
    '{EscCode, 1'b0, 1'b1, 2'd0, 8'h00,   8'h00,   8'h00},
    '{8'h41,   1'b0, 1'b1, 2'd2, NotRepr, 8'h41,   8'h00},  // miss, then 'A'
    '{EscCode, 1'b0, 1'b1, 2'd0, 8'h00,   8'h00,   8'h00},
    '{EscCode, 1'b0, 1'b1, 2'd1, NotRepr, 8'h00,   8'h00},  // miss, re-armed
    '{EscCode, 1'b1, 1'b1, 2'd2, NotRepr, NotRepr, 8'h00},  // miss, escape at end
    '{EscCode, 1'b0, 1'b1, 2'd0, 8'h00,   8'h00,   8'h00},
    '{8'h80,   1'b0, 1'b1, 2'd1, NotRepr, 8'h00,   8'h00},  // miss on dropped byte
    '{EscCode, 1'b0, 1'b1, 2'd0, 8'h00,   8'h00,   8'h00},
    '{8'h7F,   1'b1, 1'b1, 2'd3, NotRepr, 8'hC3,   8'hA0},  // three bytes out
    '{EscCode, 1'b0, 1'b1, 2'd0, 8'h00,   8'h00,   8'h00},
    '{8'd20,   1'b1, 1'b1, 2'd1, 8'h5E,   8'h00,   8'h00},  // hit ignores last flag
    '{8'h1A,   1'b0, 1'b0, 2'd0, 8'h00,   8'h00,   8'h00},
    '{8'h5B,   1'b1, 1'b0, 2'd0, 8'h00,   8'h00,   8'h00}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b1;

  gsm2u_in_if  in_if ();
  gsm2u_out_if out_if ();

  gsm_alphabet_to_utf8 u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .out_if (out_if)
  );

  // Bytes still owed by the block, oldest first
  utf8_beat_t utf8_due_q[$];
  // Bytes caused by the request being predicted
  utf8_beat_t step_q[$];
  utf8_beat_t head_due;
  logic       esc_armed;
  int         idle_pct;
  int         stall_pct;
  int         err_cnt;

  always #2 clk_i = ~clk_i;

  // Run limit, far above the slowest legal run
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic void add_byte(input logic [7:0] b);
    if (step_q.size() < MaxBytes) step_q.push_back('{utf8_byte: b, last_of_run: 1'b0});
  endfunction

  function automatic void add_code_point(input logic [15:0] cp);
    if (cp < 16'h0080) begin
      add_byte(cp[7:0]);
    end else if (cp < 16'h0800) begin
      add_byte({3'b110, cp[10:6]});
      add_byte({2'b10, cp[5:0]});
    end else begin
      add_byte({4'b1110, cp[15:12]});
      add_byte({2'b10, cp[11:6]});
      add_byte({2'b10, cp[5:0]});
    end
  endfunction

  function automatic void mark_run_end();
    if (step_q.size() > 0) step_q[step_q.size()-1].last_of_run = 1'b1;
  endfunction

  // Converter behavior for one accepted septet; fills step_q, updates esc_armed
  function automatic void convert_septet(input logic [7:0] b, input logic last);
    logic hit;
    step_q.delete();
    hit = 1'b0;
    if (esc_armed) begin
      esc_armed = 1'b0;
      for (int i = 0; i < 10; i++) begin
        if (!hit && ExtKey[i] == b) begin
          add_code_point(ExtCp[i]);
          hit = 1'b1;
        end
      end
      if (!hit) add_byte(NotRepr);
    end
    if (!hit) begin
      if (b[7]) begin
        // above the alphabet: nothing out
      end else if (b == EscCode && !last) begin
        esc_armed = 1'b1;
      end else begin
        add_code_point(SeptetCp[b[6:0]]);
      end
    end
    mark_run_end();
  endfunction

  // Present one request and hold it until the block takes it
  task automatic offer_septet(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid           <= 1'b1;
    in_if.gsm_byte        <= b;
    in_if.last_in_message <= last;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  task automatic owe_step();
    foreach (step_q[k]) utf8_due_q.push_back(step_q[k]);
  endtask

  // Stop sending and let every owed byte come out
  task automatic drain_outputs();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (utf8_due_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_septet();
    int r;
    r = $urandom_range(99);
    if (esc_armed && r < 65) return ExtKey[$urandom_range(9)];
    r = $urandom_range(99);
    if (r < 6) return 8'($urandom_range(255, 128));
    if (r < 22) return EscCode;
    return 8'($urandom_range(127));
  endfunction

  // Output side: check each taken byte, then pick next cycle's ready
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (utf8_due_q.size() == 0) begin
          $error("unexpected output: utf8_byte %02h last_of_run %0b",
                 out_if.utf8_byte, out_if.last_of_run);
          err_cnt++;
        end else begin
          head_due = utf8_due_q.pop_front();
          if (out_if.utf8_byte !== head_due.utf8_byte) begin
            $error("utf8_byte: expected %02h, got %02h",
                   head_due.utf8_byte, out_if.utf8_byte);
            err_cnt++;
          end
          if (out_if.last_of_run !== head_due.last_of_run) begin
            $error("last_of_run: expected %0b, got %0b",
                   head_due.last_of_run, out_if.last_of_run);
            err_cnt++;
          end
        end
      end
      out_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Main sequence
  initial begin
    int sent;
    int msg_len;
    int phase;
    logic [7:0] sb;
    logic [7:0] tb;
    // reset edge lands once every process waits on it
    rst_ni                <= 1'b0;
    in_if.valid           = 1'b0;
    in_if.gsm_byte        = '0;
    in_if.last_in_message = 1'b0;
    esc_armed = 1'b0;
    idle_pct  = 0;
    stall_pct = 0;
    err_cnt   = 0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table, no idling
    for (int i = 0; i < NumDirRows; i++) begin
      offer_septet(DirRows[i].septet, DirRows[i].last);
      convert_septet(DirRows[i].septet, DirRows[i].last);
      if (DirRows[i].typed) begin
        step_q.delete();
        for (int j = 0; j < DirRows[i].cnt; j++) begin
          tb = (j == 0) ? DirRows[i].b0 : (j == 1) ? DirRows[i].b1 : DirRows[i].b2;
          add_byte(tb);
        end
        mark_run_end();
      end
      owe_step();
    end
    drain_outputs();

    // Random messages over four idling mixes; sender holds off between them
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 79; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 79; end
        default: begin idle_pct = 13; stall_pct = 13; end
      endcase
      sent = 0;
      while (sent < RandItems / 4) begin
        msg_len = $urandom_range(10, 1);
        for (int k = 0; k < msg_len; k++) begin
          sb = pick_septet();
          offer_septet(sb, k == msg_len - 1);
          convert_septet(sb, k == msg_len - 1);
          owe_step();
          sent++;
        end
      end
      drain_outputs();
    end

    // Nothing more should appear
    repeat (DrainWait) @(posedge clk_i);
    if (utf8_due_q.size() != 0) begin
      $error("%0d output bytes never arrived", utf8_due_q.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/gsm2u_pkg.sv
hdl/gsm2u_if.sv
hdl/gsm2u_front.sv
hdl/gsm2u_fifo.sv
hdl/gsm2u_back.sv
hdl/gsm_alphabet_to_utf8.sv
hdl/gsm2u_checker.sv
bench/testbench.sv
